>>> sv/splb_pkg.sv
package splb_pkg;

	localparam logic [2:0] DISPOSE_RESTORE = 3'd2;

	typedef enum logic [1:0] {
		REQ_LINE    = 2'd0,
		REQ_PALETTE = 2'd1,
		REQ_PIXEL   = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_SCALE    = 2'd0,
		CFG_ORIGIN_X = 2'd1,
		CFG_ORIGIN_Y = 2'd2
	} cfg_idx_t;

	typedef logic signed [25:0] pos_t;

	typedef struct packed {
		logic [16:0] scale;
		logic [20:0] origin_x;
		logic [20:0] origin_y;
	} cfg_t;

	typedef struct packed {
		req_t        kind;
		logic        first_line;
		logic [2:0]  disposal;
		logic [11:0] left;
		logic [12:0] width;
		logic        transp_en;
		logic [7:0]  transp_idx;
		logic [7:0]  pix;
		logic [28:0] prod_r0;
		logic [29:0] prod_r1;
		logic [28:0] prod_c0;
		logic [30:0] prod_c1;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [12:0] lo;
		logic [12:0] hi;
	} span_t;

	typedef struct packed {
		logic        clear;
		logic [8:0]  col_start;
		logic [8:0]  col_end;
		logic [8:0]  row_start;
		logic [8:0]  row_end;
		logic [15:0] color;
	} res_t;

	// unsigned magnitude plus signed origin
	function automatic pos_t offset(logic [23:0] mag, logic [20:0] org);
		pos_t m;
		pos_t o;
		m = pos_t'({2'b00, mag});
		o = pos_t'($signed(org));
		return m + o;
	endfunction

	// clip [lo, hi) to [0, limit)
	function automatic span_t make_span(pos_t lo, pos_t hi, logic [12:0] limit);
		pos_t  lo_c;
		pos_t  hi_c;
		pos_t  lim;
		span_t s;
		lim  = pos_t'({13'd0, limit});
		lo_c = (lo < 0) ? '0 : lo;
		hi_c = (hi > lim) ? lim : hi;
		s.ok = (hi_c > lo_c);
		s.lo = lo_c[12:0];
		s.hi = hi_c[12:0];
		return s;
	endfunction

endpackage

>>> sv/splb_cfg.sv
module splb_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	output splb_pkg::cfg_t     cfg
);
	import splb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale    <= 17'd256;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCALE: begin
					cfg_q.scale <= cfg_data[16:0];
				end
				CFG_ORIGIN_X: begin
					cfg_q.origin_x <= cfg_data;
				end
				CFG_ORIGIN_Y: begin
					cfg_q.origin_y <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sv/splb_front.sv
module splb_front #(
	parameter int PALETTE_DEPTH = 256,
	parameter int SOURCE_MAX    = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                take,
	input  splb_pkg::req_t      req_type,
	input  logic                first_line,
	input  logic [2:0]          disposal,
	input  logic [11:0]         line_row,
	input  logic [11:0]         line_left,
	input  logic [12:0]         line_width,
	input  logic                has_transparency,
	input  logic [7:0]          transparent_index,
	input  logic [7:0]          pixel_index,
	input  logic [15:0]         palette_color,
	input  splb_pkg::cfg_t      cfg,
	output logic                valid,
	output splb_pkg::item_t     item,
	output logic [15:0]         color
);
	import splb_pkg::*;

	localparam int IdxW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SrcCap = (SOURCE_MAX < 8191) ? SOURCE_MAX : 8191;

	logic [15:0]     pal_mem [PALETTE_DEPTH];
	logic [IdxW-1:0] pal_addr;
	logic            pal_hit;
	logic [12:0]     w_sat;
	item_t           item_next;

	logic            valid_s1;
	item_t           item_s1;
	logic [15:0]     color_raw_s1;
	logic            pal_hit_s1;

	assign pal_addr = pixel_index[IdxW-1:0];
	assign pal_hit  = (32'(pixel_index) < PALETTE_DEPTH);
	assign w_sat    = (line_width > 13'(SrcCap)) ? 13'(SrcCap) : line_width;

	always_comb begin
		item_next.kind       = req_type;
		item_next.first_line = first_line;
		item_next.disposal   = disposal;
		item_next.left       = line_left;
		item_next.width      = w_sat;
		item_next.transp_en  = has_transparency;
		item_next.transp_idx = transparent_index;
		item_next.pix        = pixel_index;
		item_next.prod_r0    = 29'(line_row) * 29'(cfg.scale);
		item_next.prod_r1    = 30'(13'(line_row) + 13'd1) * 30'(cfg.scale);
		item_next.prod_c0    = 29'(line_left) * 29'(cfg.scale);
		item_next.prod_c1    = 31'(14'(line_left) + 14'(w_sat)) * 31'(cfg.scale);
	end

	always_ff @(posedge clk) begin
		if (in_fire && req_type == REQ_PALETTE && pal_hit) begin
			pal_mem[pal_addr] <= palette_color;
		end
		if (in_fire) begin
			color_raw_s1 <= pal_mem[pal_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1    <= item_next;
			pal_hit_s1 <= pal_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	assign valid = valid_s1;
	assign item  = item_s1;
	assign color = pal_hit_s1 ? color_raw_s1 : 16'd0;

endmodule

>>> sv/splb_draw.sv
module splb_draw #(
	parameter int PANEL_WIDTH  = 466,
	parameter int PANEL_HEIGHT = 466,
	parameter int SOURCE_MAX   = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  splb_pkg::item_t     item,
	input  logic [15:0]         color,
	input  splb_pkg::cfg_t      cfg,
	input  logic                out_ready,
	output logic                out_valid,
	output splb_pkg::res_t      res
);
	import splb_pkg::*;

	localparam int          SrcCap      = (SOURCE_MAX < 8191) ? SOURCE_MAX : 8191;
	localparam logic [12:0] LimW        = 13'(PANEL_WIDTH);
	localparam logic [12:0] LimH        = 13'(PANEL_HEIGHT);
	localparam bit          NarrowPanel = (PANEL_WIDTH <= 511) && (PANEL_HEIGHT <= 511);

	logic [2:0]  last_disp_q;
	logic [12:0] cnt_q;
	logic [12:0] width_q;
	logic        transp_en_q;
	logic [7:0]  transp_idx_q;
	logic [11:0] left_q;
	span_t       rows_q;
	span_t       cols_q;
	logic        out_valid_q;
	res_t        res_q;

	span_t       rows_new;
	span_t       cols_new;
	logic        clear_hit;
	logic        in_line;
	logic        is_transp;
	logic [13:0] cx;
	logic [30:0] cx_prod;
	pos_t        a_raw;
	pos_t        b_raw;
	pos_t        a_sel;
	pos_t        b_sel;
	pos_t        a_c;
	pos_t        b_c;
	pos_t        x0;
	pos_t        x1;
	logic        pix_emit;
	logic        emit;
	res_t        res_next;

	always_comb begin
		rows_new = make_span(offset(24'(item.prod_r0[28:8]), cfg.origin_y),
			offset(24'(item.prod_r1[29:8]), cfg.origin_y), LimH);
		cols_new = make_span(offset(24'(item.prod_c0[28:8]), cfg.origin_x),
			offset(24'(item.prod_c1[30:8]), cfg.origin_x), LimW);
	end

	assign clear_hit = item.first_line && (last_disp_q == DISPOSE_RESTORE);
	assign in_line   = (cnt_q < width_q);
	assign is_transp = transp_en_q && (item.pix == transp_idx_q);

	// rounded-up column bounds of the current source column
	always_comb begin
		cx      = 14'(left_q) + 14'(cnt_q);
		cx_prod = 31'(cx) * 31'(cfg.scale);
		a_raw   = offset(24'((32'(cx_prod) + 32'd255) >> 8), cfg.origin_x);
		b_raw   = offset(24'((32'(cx_prod) + 32'(cfg.scale) + 32'd255) >> 8), cfg.origin_x);
		x0      = pos_t'({13'd0, cols_q.lo});
		x1      = pos_t'({13'd0, cols_q.hi});
		a_sel   = (!transp_en_q && cnt_q == '0) ? x0 : a_raw;
		b_sel   = (!transp_en_q && (14'(cnt_q) + 14'd1 == 14'(width_q))) ? x1 : b_raw;
		a_c     = (a_sel < x0) ? x0 : a_sel;
		b_c     = (b_sel > x1) ? x1 : b_sel;
	end

	assign pix_emit = rows_q.ok && cols_q.ok && in_line && !is_transp && (b_c > a_c);

	always_comb begin
		emit     = 1'b0;
		res_next = '0;
		unique case (item.kind)
			REQ_LINE: begin
				emit           = clear_hit;
				res_next.clear = 1'b1;
			end
			REQ_PIXEL: begin
				emit               = pix_emit;
				res_next.col_start = a_c[8:0];
				res_next.col_end   = b_c[8:0];
				res_next.row_start = rows_q.lo[8:0];
				res_next.row_end   = rows_q.hi[8:0];
				res_next.color     = color;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_disp_q  <= '0;
			cnt_q        <= '0;
			width_q      <= '0;
			transp_en_q  <= 1'b0;
			transp_idx_q <= '0;
			left_q       <= '0;
			rows_q       <= '0;
			cols_q       <= '0;
		end else if (take) begin
			unique case (item.kind)
				REQ_LINE: begin
					if (item.first_line) begin
						last_disp_q <= item.disposal;
					end
					cnt_q        <= '0;
					width_q      <= item.width;
					transp_en_q  <= item.transp_en;
					transp_idx_q <= item.transp_idx;
					left_q       <= item.left;
					rows_q       <= rows_new;
					cols_q       <= cols_new;
				end
				REQ_PIXEL: begin
					if (cnt_q != 13'(SrcCap)) begin
						cnt_q <= cnt_q + 13'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_line_resets_count: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.kind == REQ_LINE |=> cnt_q == '0)
		else $error("pixel count not cleared by line start");

	a_clear_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.clear |-> res_q.col_start == '0 && res_q.col_end == '0
			&& res_q.row_start == '0 && res_q.row_end == '0 && res_q.color == '0)
		else $error("clear result carries a rectangle");

	a_fill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		NarrowPanel && out_valid_q && !res_q.clear |->
			res_q.col_start < res_q.col_end && res_q.row_start < res_q.row_end)
		else $error("empty fill rectangle emitted");

	a_fill_in_panel: assert property (@(posedge clk) disable iff (!arst_n)
		NarrowPanel && out_valid_q && !res_q.clear |->
			32'(res_q.col_end) <= PANEL_WIDTH && 32'(res_q.row_end) <= PANEL_HEIGHT)
		else $error("fill beyond panel edge");

	a_excess_pixel_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.kind == REQ_PIXEL && !in_line |=> !out_valid_q)
		else $error("pixel past line width produced a fill");
`endif

endmodule

>>> sv/scaled_palette_line_blitter.sv
// Scaled palette line blitter.
// Input stream (s_axis_*): one item per transfer; tuser holds the request kind
// (line start, palette write, source pixel). Palette writes load the color
// table; a line start sets the line geometry and may emit a frame clear; each
// source pixel emits at most one rectangle fill of its palette color.
// Output stream (m_axis_*): one rectangle fill or frame clear per transfer;
// tuser is the clear flag.
// Configuration (cfg_*): scale and origin registers, always ready; write them
// only while the block is idle.
// Pipeline: an item is held in the input register, its result in the output
// register. Throughput: one item per cycle while no result is stalled, set by
// the single compute stage between the input register and the output register.
// Stall: when the receiver holds tready low the result waits in the output
// register; the compute stage stops and s_axis_tready falls once an item waits
// in the input register, until the result is taken, whether or not the next
// item has a result. While no result waits, items pass at one per cycle.
// Reset: scale returns to 1.0, origins to zero, line state to an empty span;
// the palette content is not cleared and must be written before it is used.
module scaled_palette_line_blitter #(
	parameter int PANEL_WIDTH   = 466,
	parameter int PANEL_HEIGHT  = 466,
	parameter int PALETTE_DEPTH = 256,
	parameter int SOURCE_MAX    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_line, disposal, line_row, line_left, line_width, has_transparency,
	// transparent_index, pixel_index, palette_color, zero pad
	input  logic [79:0] s_axis_tdata,
	// req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// col_start, col_end, row_start, row_end, fill_color, zero pad
	output logic [55:0] m_axis_tdata,
	// clear_screen
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);
	import splb_pkg::*;

	cfg_t        cfg;
	logic        in_fire;
	logic        take;
	logic        valid_s1;
	item_t       item_s1;
	logic [15:0] color_s1;
	logic        out_valid;
	res_t        res;

	assign take          = valid_s1 && (!out_valid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || take;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	splb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	splb_front #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.SOURCE_MAX    (SOURCE_MAX)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_fire           (in_fire),
		.take              (take),
		.req_type          (req_t'(s_axis_tuser)),
		.first_line        (s_axis_tdata[0]),
		.disposal          (s_axis_tdata[3:1]),
		.line_row          (s_axis_tdata[15:4]),
		.line_left         (s_axis_tdata[27:16]),
		.line_width        (s_axis_tdata[40:28]),
		.has_transparency  (s_axis_tdata[41]),
		.transparent_index (s_axis_tdata[49:42]),
		.pixel_index       (s_axis_tdata[57:50]),
		.palette_color     (s_axis_tdata[73:58]),
		.cfg               (cfg),
		.valid             (valid_s1),
		.item              (item_s1),
		.color             (color_s1)
	);

	splb_draw #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.SOURCE_MAX   (SOURCE_MAX)
	) u_draw (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item_s1),
		.color     (color_s1),
		.cfg       (cfg),
		.out_ready (m_axis_tready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tuser  = res.clear;
	assign m_axis_tdata  = {4'd0, res.color, res.row_end, res.row_start,
		res.col_end, res.col_start};

endmodule

>>> sim/scaled_palette_line_blitter_test.sv
`timescale 1ns / 100ps

module scaled_palette_line_blitter_test;

	import splb_pkg::*;

	localparam int PANEL_W         = 466;
	localparam int PANEL_H         = 466;
	localparam int SOURCE_LIMIT    = 4096;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STUCK_LIMIT     = 4000;
	localparam int REPORT_CAP      = 40;
	localparam int PHASES          = 10;

	// input item as carried on s_axis_tdata, last field in the lowest bits
	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] color;
		logic [7:0]  pix;
		logic [7:0]  transp_idx;
		logic        transp_en;
		logic [12:0] width;
		logic [11:0] left;
		logic [11:0] row;
		logic [2:0]  disposal;
		logic        first_line;
	} blit_req_t;

	// fill as carried on m_axis_tdata
	typedef struct packed {
		logic [3:0]  pad;
		logic [15:0] color;
		logic [8:0]  row_end;
		logic [8:0]  row_start;
		logic [8:0]  col_end;
		logic [8:0]  col_start;
	} fill_t;

	typedef struct packed {
		logic  clear;
		fill_t fill;
	} draw_t;

	typedef struct {
		bit     ok;
		longint lo;
		longint hi;
	} extent_t;

	class fill_scoreboard;
		draw_t       fills_due[$];
		int          errors = 0;
		longint      scale = 256;
		longint      origin_x = 0;
		longint      origin_y = 0;
		logic [15:0] palette [256];
		logic [2:0]  last_disp = '0;
		int          pix_cnt = 0;
		longint      line_left = 0;
		int          line_width = 0;
		logic        transp_en = 1'b0;
		logic [7:0]  transp_idx = '0;
		extent_t     rows = '{0, 0, 0};
		extent_t     cols = '{0, 0, 0};

		function int pending();
			return fills_due.size();
		endfunction

		function void set_register(cfg_idx_t idx, logic [20:0] value);
			case (idx)
				CFG_SCALE:    scale = longint'(value[16:0]);
				CFG_ORIGIN_X: origin_x = longint'($signed(value));
				CFG_ORIGIN_Y: origin_y = longint'($signed(value));
				default: ;
			endcase
		endfunction

		function extent_t clip(longint lo, longint hi, longint lim);
			extent_t e;
			e.lo = (lo < 0) ? 0 : lo;
			e.hi = (hi > lim) ? lim : hi;
			e.ok = e.hi > e.lo;
			return e;
		endfunction

		function void predict_fill(req_t kind, blit_req_t r);
			draw_t  d;
			longint row;
			longint cx;
			longint a;
			longint b;
			int     cnt;
			d = '0;
			case (kind)
				REQ_PALETTE: palette[r.pix] = r.color;
				REQ_LINE: begin
					if (r.first_line) begin
						if (last_disp == DISPOSE_RESTORE) begin
							d.clear = 1'b1;
							fills_due.push_back(d);
						end
						last_disp = r.disposal;
					end
					line_width = (r.width > SOURCE_LIMIT) ? SOURCE_LIMIT : int'(r.width);
					line_left  = longint'(r.left);
					transp_en  = r.transp_en;
					transp_idx = r.transp_idx;
					pix_cnt    = 0;
					row  = longint'(r.row);
					rows = clip(origin_y + ((row * scale) >>> 8),
						origin_y + (((row + 1) * scale) >>> 8), PANEL_H);
					cols = clip(origin_x + ((line_left * scale) >>> 8),
						origin_x + (((line_left + line_width) * scale) >>> 8), PANEL_W);
				end
				REQ_PIXEL: begin
					cnt = pix_cnt;
					if (pix_cnt < SOURCE_LIMIT)
						pix_cnt++;
					if (rows.ok && cols.ok && cnt < line_width &&
							!(transp_en && r.pix == transp_idx)) begin
						cx = line_left + cnt;
						a  = origin_x + ((cx * scale + 255) >>> 8);
						b  = origin_x + (((cx + 1) * scale + 255) >>> 8);
						// opaque edge pixels stretch over the rest of the span
						if (!transp_en && cnt == 0)
							a = cols.lo;
						if (!transp_en && cnt + 1 == line_width)
							b = cols.hi;
						if (a < cols.lo)
							a = cols.lo;
						if (b > cols.hi)
							b = cols.hi;
						if (b > a) begin
							d.fill.col_start = a[8:0];
							d.fill.col_end   = b[8:0];
							d.fill.row_start = rows.lo[8:0];
							d.fill.row_end   = rows.hi[8:0];
							d.fill.color     = palette[r.pix];
							fills_due.push_back(d);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		endtask

		task check_fill(logic clear, fill_t got);
			draw_t want;
			if (fills_due.size() == 0) begin
				report("unexpected fill transfer", 64'({clear, got}), '0);
				return;
			end
			want = fills_due.pop_front();
			if (clear !== want.clear)
				report("clear_screen", 64'(clear), 64'(want.clear));
			if (got.col_start !== want.fill.col_start)
				report("col_start", 64'(got.col_start), 64'(want.fill.col_start));
			if (got.col_end !== want.fill.col_end)
				report("col_end", 64'(got.col_end), 64'(want.fill.col_end));
			if (got.row_start !== want.fill.row_start)
				report("row_start", 64'(got.row_start), 64'(want.fill.row_start));
			if (got.row_end !== want.fill.row_end)
				report("row_end", 64'(got.row_end), 64'(want.fill.row_end));
			if (got.color !== want.fill.color)
				report("fill_color", 64'(got.color), 64'(want.fill.color));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = REQ_NONE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SCALE;
	logic [20:0] cfg_data = '0;

	fill_scoreboard sb = new();
	int             burst_left = 1;
	int             total_sent = 0;
	int             stuck_cycles = 0;
	bit             hold_armed = 1'b0;
	bit             hold_done = 1'b0;
	bit             loaded [256];
	logic [7:0]     loaded_list[$];

	scaled_palette_line_blitter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_fill(m_axis_tuser[0], fill_t'(m_axis_tdata));
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[scaled_palette_line_blitter] ERROR");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// receiver: stall modes of random length, plus one long hold-off
	initial begin : receiver
		int mode;
		int mode_left;
		int beat;
		mode      = 0;
		mode_left = 0;
		beat      = 0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				beat++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (beat % 4) != 3;
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic blit_req_t noise_req();
		logic [95:0] raw;
		blit_req_t   r;
		raw   = {$urandom, $urandom, $urandom};
		r     = raw[79:0];
		r.pad = '0;
		return r;
	endfunction

	function automatic blit_req_t line_req(logic first, logic [2:0] disp, logic [11:0] row,
			logic [11:0] left, logic [12:0] width, logic t_en, logic [7:0] t_idx);
		blit_req_t r;
		r            = noise_req();
		r.first_line = first;
		r.disposal   = disp;
		r.row        = row;
		r.left       = left;
		r.width      = width;
		r.transp_en  = t_en;
		r.transp_idx = t_idx;
		return r;
	endfunction

	function automatic blit_req_t pix_req(logic [7:0] idx);
		blit_req_t r;
		r     = noise_req();
		r.pix = idx;
		return r;
	endfunction

	function automatic logic [7:0] pick_loaded_index();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	// canvas coordinate that mostly lands on the panel under the current setting
	function automatic logic [11:0] aim_coord(longint org, longint extra);
		longint lo;
		longint hi;
		if (sb.scale == 0 || $urandom_range(0, 4) == 0)
			return 12'($urandom_range(0, 4095));
		lo = ((-org) * 256) / sb.scale - extra;
		hi = ((PANEL_W - org) * 256) / sb.scale;
		if (lo < 0)
			lo = 0;
		if (hi > 4095)
			hi = 4095;
		if (hi < lo)
			return 12'($urandom_range(0, 4095));
		return 12'($urandom_range(int'(lo), int'(hi)));
	endfunction

	task automatic send_req(req_t kind, blit_req_t r);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= r;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.predict_fill(kind, r);
		if (kind != REQ_NONE)
			total_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic load_palette(logic [7:0] addr, logic [15:0] color);
		blit_req_t r;
		r       = noise_req();
		r.pix   = addr;
		r.color = color;
		send_req(REQ_PALETTE, r);
		if (!loaded[addr]) begin
			loaded[addr] = 1'b1;
			loaded_list.push_back(addr);
		end
	endtask

	// drain all fills, then let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_setting(logic [16:0] scale, int ox, int oy);
		cfg_idx_t    order [3];
		logic [20:0] vals [3];
		int          k;
		order = '{CFG_SCALE, CFG_ORIGIN_X, CFG_ORIGIN_Y};
		vals  = '{{4'd0, scale}, ox[20:0], oy[20:0]};
		for (k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[k];
			cfg_data  <= vals[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.set_register(order[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int quota);
		int          sent;
		int          n;
		int          k;
		int          roll;
		logic [12:0] w;
		logic [2:0]  disp;
		logic        t_en;
		logic [7:0]  t_idx;
		logic [11:0] row;
		logic [11:0] left;
		sent = 0;
		while (sent < quota) begin
			if (total_sent >= 60)
				hold_armed = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				load_palette(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				sent++;
			end else if (roll < 16) begin
				send_req(REQ_NONE, noise_req());
			end else if (roll < 20) begin
				// stray pixel outside a well-formed run
				send_req(REQ_PIXEL, pix_req(pick_loaded_index()));
				sent++;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					w = 13'($urandom_range(1, 24));
				else if (roll < 90)
					w = 13'($urandom_range(25, 120));
				else if (roll < 97)
					w = 13'($urandom_range(121, 4096));
				else
					w = 13'($urandom_range(4097, 8191));
				disp  = ($urandom_range(0, 2) == 0) ? DISPOSE_RESTORE :
					3'($urandom_range(0, 7));
				t_en  = ($urandom_range(0, 9) < 3);
				t_idx = 8'($urandom_range(0, 255));
				row   = aim_coord(sb.origin_y, 1);
				left  = aim_coord(sb.origin_x, longint'(w));
				send_req(REQ_LINE, line_req($urandom_range(0, 9) < 3, disp, row, left, w,
					t_en, t_idx));
				sent++;
				n    = (w <= 120) ? int'(w) : $urandom_range(1, 24);
				roll = $urandom_range(0, 9);
				if (roll == 0)
					n += $urandom_range(1, 3);
				else if (roll == 1)
					n = $urandom_range(0, n);
				for (k = 0; k < n; k++) begin
					if (t_en && $urandom_range(0, 4) == 0)
						send_req(REQ_PIXEL, pix_req(t_idx));
					else
						send_req(REQ_PIXEL, pix_req(pick_loaded_index()));
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [16:0] ph_scale [PHASES];
		int          ph_ox [PHASES];
		int          ph_oy [PHASES];
		int          ph_items [PHASES];
		int          p;
		ph_scale = '{256, 512, 100, 1, 131071, 0, 700, 256, 181, 384};
		ph_ox    = '{0, -100, 7, 0, -1048576, 12, -300, 466, 150, -7};
		ph_oy    = '{0, 40, -3, 0, -20, 12, -60, -1048576, 200, 466};
		ph_items = '{85, 90, 90, 30, 30, 15, 90, 25, 60, 15};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: scale 1.0, origin at the panel corner
		load_palette(8'h00, 16'h0000);
		load_palette(8'hFF, 16'hFFFF);
		load_palette(8'h5A, 16'hA5C3);
		load_palette(8'hA5, 16'h5A3C);
		send_req(REQ_NONE, noise_req());
		send_req(REQ_LINE, line_req(1'b1, DISPOSE_RESTORE, 12'd0, 12'd0, 13'd4, 1'b0, 8'h00));
		send_req(REQ_PIXEL, pix_req(8'hFF));
		send_req(REQ_PIXEL, pix_req(8'h00));
		send_req(REQ_PIXEL, pix_req(8'h5A));
		send_req(REQ_PIXEL, pix_req(8'hA5));
		send_req(REQ_PIXEL, pix_req(8'h00));
		// frame clear, bottom-right corner clipped, transparency on
		send_req(REQ_LINE, line_req(1'b1, 3'd3, 12'd465, 12'd463, 13'd5, 1'b1, 8'h5A));
		send_req(REQ_PIXEL, pix_req(8'h5A));
		send_req(REQ_PIXEL, pix_req(8'h00));
		send_req(REQ_PIXEL, pix_req(8'hFF));
		send_req(REQ_PIXEL, pix_req(8'hA5));
		// rows off the panel, overlong width
		send_req(REQ_LINE, line_req(1'b0, 3'd7, 12'd4095, 12'd0, 13'd8191, 1'b0, 8'hFF));
		send_req(REQ_PIXEL, pix_req(8'hFF));
		// zero width
		send_req(REQ_LINE, line_req(1'b0, 3'd0, 12'd10, 12'd0, 13'd0, 1'b0, 8'h00));
		send_req(REQ_PIXEL, pix_req(8'h00));
		// single pixel line, both edges stretch
		send_req(REQ_LINE, line_req(1'b0, 3'd0, 12'd5, 12'd20, 13'd1, 1'b0, 8'h00));
		send_req(REQ_PIXEL, pix_req(8'hA5));
		load_palette(8'hFF, 16'h1234);
		send_req(REQ_PIXEL, pix_req(8'hFF));
		settle();

		for (p = 0; p < PHASES; p++) begin
			load_setting(ph_scale[p], ph_ox[p], ph_oy[p]);
			run_random(ph_items[p]);
			settle();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[scaled_palette_line_blitter] OK");
		else
			$display("[scaled_palette_line_blitter] ERROR");
		$finish;
	end

endmodule

>>> scaled_palette_line_blitter.f
sv/splb_pkg.sv
sv/splb_cfg.sv
sv/splb_front.sv
sv/splb_draw.sv
sv/scaled_palette_line_blitter.sv
sim/scaled_palette_line_blitter_test.sv
